// ----- rtl/assert_macros.svh -----
// -----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL: implication in the same cycle and
// in the next cycle, both clocked on the rising edge and off during reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds -> expr holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: same-cycle implication");

// cond holds -> expr holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/rcpw_pkg.sv -----
// -----------------------------------------------------------------------------
// rcpw_pkg
// Shared widths, defaults and register indexes of the pulse-width meter.
// -----------------------------------------------------------------------------
package rcpw_pkg;

   localparam int CHANNEL_W = 3;
   localparam int TS_W      = 32;
   localparam int WIDTH_W   = 16;
   localparam int CSR_IDX_W = 1;

   localparam int DEF_CHANNELS     = 5;
   localparam int DEF_TICKS_PER_US = 80;

   localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = 16'd1000;
   localparam logic [WIDTH_W-1:0] MAX_WIDTH_RESET = 16'd2000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_WIDTH = 1'b0,
      CSR_MAX_WIDTH = 1'b1
   } csr_index_type;

endpackage

// ----- rtl/rcpw_tick_div.sv -----
// -----------------------------------------------------------------------------
// rcpw_tick_div
// Registered tick-to-microsecond conversion: exact division of a 32-bit tick
// count by a constant through a reciprocal multiply, saturated to 16 bits.
// -----------------------------------------------------------------------------
module rcpw_tick_div
   import rcpw_pkg::*;
#(
   parameter int TICKS_PER_US = DEF_TICKS_PER_US
) (
   input  logic               clock,
   input  logic               load,
   input  logic [TS_W-1:0]    ticks,
   output logic [WIDTH_W-1:0] width_us
);

   // m = ceil(2^(32+l) / d), l = ceil(log2 d): exact floor for every 32-bit n
   localparam int PRE_SHIFT = $clog2(TICKS_PER_US);
   localparam int SHIFT     = TS_W + PRE_SHIFT;
   localparam int MAGIC_W   = TS_W + 1;
   localparam int PROD_W    = TS_W + MAGIC_W;
   localparam logic [PROD_W-1:0] MAGIC_FULL =
      ((PROD_W'(1) << SHIFT) + PROD_W'(TICKS_PER_US) - PROD_W'(1))
      / PROD_W'(TICKS_PER_US);
   localparam logic [MAGIC_W-1:0] MAGIC = MAGIC_FULL[MAGIC_W-1:0];

   logic [PROD_W-1:0]  product;
   logic [PROD_W-1:0]  quotient;
   logic [WIDTH_W-1:0] width_in;
   logic [WIDTH_W-1:0] width_ff;

   always_comb begin
      product  = PROD_W'(ticks) * PROD_W'(MAGIC);
      quotient = product >> SHIFT;
      if (|quotient[PROD_W-1:WIDTH_W]) begin
         width_in = {WIDTH_W{1'b1}};
      end else begin
         width_in = quotient[WIDTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         width_ff <= width_in;
      end
   end

   assign width_us = width_ff;

endmodule

// ----- rtl/rc_pulse_width_capture.sv -----
// -----------------------------------------------------------------------------
// rc_pulse_width_capture
// Multi-channel RC servo pulse-width meter with a range health flag.
// -----------------------------------------------------------------------------
// Each capture event (channel, edge polarity, 32-bit timestamp) yields exactly
// one result. An opening edge stores the timestamp as the channel's start; a
// closing edge stores (timestamp - start) mod 2^32 divided by TICKS_PER_US,
// saturated at 65535, as the channel's width. The result carries the channel's
// width after the event, whether it was just measured, and healthy, which is
// set only when every channel's width lies in min_width_us..max_width_us.
// Channels at or above CHANNELS change nothing and report width 0. The block
// is a four-register pipeline (input, tick difference, reciprocal multiply,
// result) that takes one event per clock while req_ready is high; each stage
// moves whenever the one after it is empty or moving, so a waiting result
// stops new events only once all four stages hold an event.
// Widths and start times reset to zero, so healthy starts low. CSR writes
// (index 0 min, index 1 max) take effect at once and belong to idle periods.
// -----------------------------------------------------------------------------
module rc_pulse_width_capture
   import rcpw_pkg::*;
#(
   parameter int CHANNELS     = DEF_CHANNELS,
   parameter int TICKS_PER_US = DEF_TICKS_PER_US
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CHANNEL_W-1:0] req_channel,
   input  logic                 req_opens_pulse,
   input  logic [TS_W-1:0]      req_timestamp,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CHANNEL_W-1:0] rsp_out_channel,
   output logic [WIDTH_W-1:0]   rsp_width_us,
   output logic                 rsp_width_updated,
   output logic                 rsp_healthy,

   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [WIDTH_W-1:0]   csr_wdata
);

`include "assert_macros.svh"

   // channel numbers at or above this are ignored
   localparam logic [CHANNEL_W:0] CH_LIMIT = (CHANNEL_W + 1)'(CHANNELS);

   // ---------------------------------------------------------------- CSRs
   logic [WIDTH_W-1:0] min_width_ff, min_width_in;
   logic [WIDTH_W-1:0] max_width_ff, max_width_in;

   always_comb begin
      min_width_in = min_width_ff;
      max_width_in = max_width_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_WIDTH: min_width_in = csr_wdata;
            CSR_MAX_WIDTH: max_width_in = csr_wdata;
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff <= MIN_WIDTH_RESET;
         max_width_ff <= MAX_WIDTH_RESET;
      end else begin
         min_width_ff <= min_width_in;
         max_width_ff <= max_width_in;
      end
   end

   // ------------------------------------------------------ stage advance
   // A stage loads when it is empty or its contents move on this edge.
   logic s0_valid_ff, s0_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic en0, en1, en2, en_out;

   assign en_out    = !rsp_valid_ff || rsp_ready;
   assign en2       = !s2_valid_ff || en_out;
   assign en1       = !s1_valid_ff || en2;
   assign en0       = !s0_valid_ff || en1;
   assign req_ready = en0;

   assign s0_valid_in  = en0    ? req_valid    : s0_valid_ff;
   assign s1_valid_in  = en1    ? s0_valid_ff  : s1_valid_ff;
   assign s2_valid_in  = en2    ? s1_valid_ff  : s2_valid_ff;
   assign rsp_valid_in = en_out ? s2_valid_ff  : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------ stage 0: input
   logic [CHANNEL_W-1:0] s0_channel_ff;
   logic                 s0_opens_ff;
   logic [TS_W-1:0]      s0_timestamp_ff;

   always_ff @(posedge clock) begin
      if (en0) begin
         s0_channel_ff   <= req_channel;
         s0_opens_ff     <= req_opens_pulse;
         s0_timestamp_ff <= req_timestamp;
      end
   end

   // ---------------------------------------- stage 1: start time, ticks
   // Start times are written as the event leaves stage 0, so the next event
   // on the same channel already sees the new value.
   logic [TS_W-1:0]      start_time_ff [CHANNELS];
   logic [TS_W-1:0]      start_time_in [CHANNELS];
   logic [TS_W-1:0]      start_sel;
   logic                 s0_in_range;

   logic [CHANNEL_W-1:0] s1_channel_ff;
   logic                 s1_in_range_ff;
   logic                 s1_measure_ff;
   logic [TS_W-1:0]      s1_ticks_ff, s1_ticks_in;

   assign s0_in_range = {1'b0, s0_channel_ff} < CH_LIMIT;

   always_comb begin
      start_sel = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         start_time_in[c] = start_time_ff[c];
         if (s0_channel_ff == CHANNEL_W'(c)) begin
            start_sel = start_time_ff[c];
            if (s0_valid_ff && en1 && s0_opens_ff) begin
               start_time_in[c] = s0_timestamp_ff;
            end
         end
      end
      s1_ticks_in = s0_timestamp_ff - start_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            start_time_ff[c] <= '0;
         end
      end else begin
         start_time_ff <= start_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_channel_ff  <= s0_channel_ff;
         s1_in_range_ff <= s0_in_range;
         s1_measure_ff  <= s0_in_range && !s0_opens_ff;
         s1_ticks_ff    <= s1_ticks_in;
      end
   end

   // ------------------------------------------- stage 2: ticks to width
   logic [CHANNEL_W-1:0] s2_channel_ff;
   logic                 s2_in_range_ff;
   logic                 s2_measure_ff;
   logic [WIDTH_W-1:0]   s2_width;

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_channel_ff  <= s1_channel_ff;
         s2_in_range_ff <= s1_in_range_ff;
         s2_measure_ff  <= s1_measure_ff;
      end
   end

   rcpw_tick_div #(
      .TICKS_PER_US (TICKS_PER_US)
   ) u_tick_div (
      .clock    (clock),
      .load     (en2),
      .ticks    (s1_ticks_ff),
      .width_us (s2_width)
   );

   // ---------------------------------- result: width store and health
   logic [WIDTH_W-1:0]   pulse_width_ff [CHANNELS];
   logic [WIDTH_W-1:0]   pulse_width_in [CHANNELS];
   logic [WIDTH_W-1:0]   width_sel;
   logic                 all_ok;

   logic [CHANNEL_W-1:0] rsp_channel_ff, rsp_channel_in;
   logic [WIDTH_W-1:0]   rsp_width_ff, rsp_width_in;
   logic                 rsp_updated_ff, rsp_updated_in;
   logic                 rsp_healthy_ff, rsp_healthy_in;

   always_comb begin
      width_sel = '0;
      all_ok    = 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
         pulse_width_in[c] = pulse_width_ff[c];
         if (s2_channel_ff == CHANNEL_W'(c)) begin
            if (s2_measure_ff) begin
               pulse_width_in[c] = s2_width;
            end
            width_sel = pulse_width_in[c];
         end
         // health judged on the widths as they stand after this event
         if (pulse_width_in[c] < min_width_ff || pulse_width_in[c] > max_width_ff) begin
            all_ok = 1'b0;
         end
      end
      rsp_channel_in = s2_channel_ff;
      rsp_width_in   = s2_in_range_ff ? width_sel : '0;
      rsp_updated_in = s2_measure_ff;
      rsp_healthy_in = all_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            pulse_width_ff[c] <= '0;
         end
      end else if (en_out && s2_valid_ff) begin
         pulse_width_ff <= pulse_width_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_channel_ff <= rsp_channel_in;
         rsp_width_ff   <= rsp_width_in;
         rsp_updated_ff <= rsp_updated_in;
         rsp_healthy_ff <= rsp_healthy_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel   = rsp_channel_ff;
   assign rsp_width_us      = rsp_width_ff;
   assign rsp_width_updated = rsp_updated_ff;
   assign rsp_healthy       = rsp_healthy_ff;

   // --------------------------------------------------------- assertions
   // a measurement is only ever reported for a real channel
   `ASSERT_IMPLIES(a_updated_in_range, clock, reset,
      rsp_valid_ff && rsp_updated_ff, {1'b0, rsp_channel_ff} < CH_LIMIT)
   // an unknown channel reports a zero width
   `ASSERT_IMPLIES(a_unknown_zero, clock, reset,
      rsp_valid_ff && ({1'b0, rsp_channel_ff} >= CH_LIMIT), rsp_width_ff == '0)
   // an event held behind a stalled result is not dropped
   `ASSERT_NEXT(a_stage2_hold, clock, reset,
      s2_valid_ff && !en_out, s2_valid_ff)

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: rc_pulse_width_capture
// Drives capture events into the pulse-width meter with random stalls on
// both handshakes. A scoreboard keeps its own copy of the start times,
// widths and limits, predicts each result and checks it field by field.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rcpw_pkg::*;

   // Pipeline is four stages deep; give a little more before touching CSRs.
   localparam int LATENCY      = 4;
   localparam int SETTLE       = LATENCY + 4;
   localparam int PHASE_EVENTS = 200;
   // Slowest legal run is roughly 1.5k events, each with the longest gap and stall,
   // so this leaves a wide margin.
   localparam int CYCLE_LIMIT  = 800000;

   localparam logic [TS_W-1:0] TICKS = DEF_TICKS_PER_US;
   localparam logic [TS_W-1:0] SAT   = 32'h0000_FFFF;

   // Closing times (ticks after the channel 0 start) around the default
   // limits: 999, 1000, 2000, 2001 us, then back to 1500 us.
   localparam int unsigned LIMIT_EDGE_TICKS [5] = '{79999, 80000, 160079, 160080, 120000};

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [WIDTH_W-1:0]   width_us;
      logic                 updated;
      logic                 healthy;
   } capture_result_type;

   // -------------------------------------------------------------------------
   // Width scoreboard: mirrors the per-channel state and queues one expected
   // result per accepted event.
   // -------------------------------------------------------------------------
   class width_scoreboard;
      logic [TS_W-1:0]    start_time [DEF_CHANNELS];
      logic [WIDTH_W-1:0] pulse_width [DEF_CHANNELS];
      logic [WIDTH_W-1:0] min_width_us;
      logic [WIDTH_W-1:0] max_width_us;
      capture_result_type expected_widths [$];
      int                 errors;

      function new();
         foreach (start_time[c]) begin
            start_time[c]  = '0;
            pulse_width[c] = '0;
         end
         min_width_us = MIN_WIDTH_RESET;
         max_width_us = MAX_WIDTH_RESET;
         errors       = 0;
      endfunction

      function void set_limits(logic [WIDTH_W-1:0] lo, logic [WIDTH_W-1:0] hi);
         min_width_us = lo;
         max_width_us = hi;
      endfunction

      function int pending();
         return expected_widths.size();
      endfunction

      function bit all_in_range();
         foreach (pulse_width[c])
            if (pulse_width[c] < min_width_us || pulse_width[c] > max_width_us)
               return 1'b0;
         return 1'b1;
      endfunction

      // Apply one accepted capture event and queue the result it must give.
      function void note_event(logic [CHANNEL_W-1:0] ch, logic opens,
                               logic [TS_W-1:0] ts);
         capture_result_type r;
         logic [TS_W-1:0] ticks;
         logic [TS_W-1:0] us;
         r = '0;
         r.channel = ch;
         if (ch < DEF_CHANNELS) begin
            if (opens) begin
               start_time[ch] = ts;
            end else begin
               ticks = ts - start_time[ch];   // mod 2^32, handles wrap
               us    = ticks / TICKS;
               pulse_width[ch] = (us > SAT) ? SAT[WIDTH_W-1:0] : us[WIDTH_W-1:0];
               r.updated = 1'b1;
            end
            r.width_us = pulse_width[ch];
         end
         r.healthy = all_in_range();
         expected_widths.push_back(r);
      endfunction

      function void check_result(capture_result_type got);
         capture_result_type want;
         if (expected_widths.size() == 0) begin
            $error("result on channel %0d with no event outstanding", got.channel);
            errors++;
            return;
         end
         want = expected_widths.pop_front();
         if (got.channel !== want.channel) begin
            $error("out_channel expected %0d actual %0d", want.channel, got.channel);
            errors++;
         end
         if (got.width_us !== want.width_us) begin
            $error("width_us expected %0d actual %0d", want.width_us, got.width_us);
            errors++;
         end
         if (got.updated !== want.updated) begin
            $error("width_updated expected %0d actual %0d", want.updated, got.updated);
            errors++;
         end
         if (got.healthy !== want.healthy) begin
            $error("healthy expected %0d actual %0d", want.healthy, got.healthy);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals; every input starts at a known value
   // -------------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_valid       = 1'b0;
   logic                 req_ready;
   logic [CHANNEL_W-1:0] req_channel     = '0;
   logic                 req_opens_pulse = 1'b0;
   logic [TS_W-1:0]      req_timestamp   = '0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CHANNEL_W-1:0] rsp_out_channel;
   logic [WIDTH_W-1:0]   rsp_width_us;
   logic                 rsp_width_updated;
   logic                 rsp_healthy;

   logic                 csr_write_en = 1'b0;
   csr_index_type        csr_index    = CSR_MIN_WIDTH;
   logic [WIDTH_W-1:0]   csr_wdata    = '0;

   width_scoreboard sb = new();

   int  events_sent = 0;
   int  cycle_count = 0;
   bit  calm        = 1'b0;   // when set, neither side idles

   rc_pulse_width_capture i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_channel       (req_channel),
      .req_opens_pulse   (req_opens_pulse),
      .req_timestamp     (req_timestamp),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_channel   (rsp_out_channel),
      .rsp_width_us      (rsp_width_us),
      .rsp_width_updated (rsp_width_updated),
      .rsp_healthy       (rsp_healthy),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int unsigned roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // -------------------------------------------------------------------------
   // Transfer monitor. Values read here are the ones before the edge, since
   // everything on both sides is updated by nonblocking assignments. The
   // event is noted before the result is checked so a queue never runs dry
   // by ordering alone.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_event(req_channel, req_opens_pulse, req_timestamp);
         if (rsp_valid && rsp_ready)
            sb.check_result(capture_result_type'{rsp_out_channel, rsp_width_us,
                                                 rsp_width_updated, rsp_healthy});
      end
   end

   // Result side: back-pressure with random stalls.
   always begin : rsp_stall
      int stall;
      @(posedge clock);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Event side
   // -------------------------------------------------------------------------

   // One capture event. Valid is left high on return so a back-to-back
   // event keeps it up; it only drops when a gap is chosen or on a drain.
   task automatic send_event(input logic [CHANNEL_W-1:0] ch, input logic opens,
                             input logic [TS_W-1:0] ts);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_channel     <= ch;
      req_opens_pulse <= opens;
      req_timestamp   <= ts;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      events_sent++;
   endtask

   // Opening edge, then closing edge 'ticks' later (may cross the wrap).
   task automatic send_pulse(input logic [CHANNEL_W-1:0] ch,
                             input logic [TS_W-1:0] t_open,
                             input logic [TS_W-1:0] ticks);
      send_event(ch, 1'b1, t_open);
      send_event(ch, 1'b0, t_open + ticks);
   endtask

   // Stop sending and wait until every expected result has come back,
   // plus a settling wait so the pipeline is truly empty.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Both limit registers, back to back; only called with the block idle.
   task automatic write_limits(input logic [WIDTH_W-1:0] lo,
                               input logic [WIDTH_W-1:0] hi);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_MIN_WIDTH;
      csr_wdata    <= lo;
      @(posedge clock);
      csr_index    <= CSR_MAX_WIDTH;
      csr_wdata    <= hi;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_limits(lo, hi);
   endtask

   function automatic logic [TS_W-1:0] ticks_for_width(int unsigned w);
      return TICKS * w + $urandom_range(0, DEF_TICKS_PER_US - 1);
   endfunction

   // Width somewhere in (or just outside) the current healthy window.
   function automatic int unsigned width_near_limits();
      int unsigned lo, hi;
      lo = (sb.min_width_us < sb.max_width_us) ? sb.min_width_us : sb.max_width_us;
      hi = (sb.min_width_us < sb.max_width_us) ? sb.max_width_us : sb.min_width_us;
      lo = (lo >= 3) ? lo - 3 : 0;
      hi = (hi <= 65532) ? hi + 3 : 65535;
      return $urandom_range(lo, hi);
   endfunction

   // Width right on a limit or one step past it.
   function automatic int unsigned width_on_limit();
      int w;
      case ($urandom_range(0, 3))
         0: w = int'(sb.min_width_us) - 1;
         1: w = int'(sb.min_width_us);
         2: w = int'(sb.max_width_us);
         default: w = int'(sb.max_width_us) + 1;
      endcase
      if (w < 0) w = 0;
      if (w > 65535) w = 65535;
      return w;
   endfunction

   // Mostly well-formed pulses with random content; the rest is stray
   // edges and events on channels the block does not have.
   task automatic send_random_item();
      int unsigned          roll;
      logic [CHANNEL_W-1:0] ch;
      logic [TS_W-1:0]      t_open;
      roll   = $urandom_range(0, 99);
      ch     = CHANNEL_W'($urandom_range(0, DEF_CHANNELS - 1));
      t_open = $urandom;
      if (roll < 50)
         send_pulse(ch, t_open, ticks_for_width(width_near_limits()));
      else if (roll < 62)
         send_pulse(ch, t_open, $urandom_range(0, 4000));
      else if (roll < 72)
         send_pulse(ch, t_open, $urandom);          // mostly saturates
      else if (roll < 80)
         send_pulse(ch, t_open, ticks_for_width(width_on_limit()));
      else if (roll < 90)
         send_event(CHANNEL_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                    $urandom);
      else
         send_event(CHANNEL_W'($urandom_range(DEF_CHANNELS, 7)),
                    1'($urandom_range(0, 1)), $urandom);
   endtask

   // One limit setting followed by a batch of random traffic.
   task automatic run_phase(input logic [WIDTH_W-1:0] lo, input logic [WIDTH_W-1:0] hi);
      int stop_at;
      int batch;
      wait_until_drained();
      write_limits(lo, hi);
      stop_at = events_sent + PHASE_EVENTS;
      batch   = 0;
      while (events_sent < stop_at) begin
         // re-pick every few dozen items: stretches with and without idling
         if (batch % 40 == 0)
            calm = ($urandom_range(0, 3) == 0);
         batch++;
         send_random_item();
      end
      calm = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset limits 1000..2000 us.
      // Closing edges with no opening edge measure from a start time of zero.
      send_event(3'd0, 1'b0, 32'd0);
      send_event(3'd1, 1'b0, 32'd120000);
      // Pulse that spans the counter wrap.
      send_pulse(3'd2, 32'hFFFF_FF00, 32'h0002_0000);
      // Longest possible pulse saturates; just under the limit does not.
      send_pulse(3'd3, 32'd0, 32'hFFFF_FFFF);
      send_pulse(3'd4, 32'd100, 32'd5242879);
      // Unused channels: nothing changes, width reads zero.
      send_event(3'd5, 1'b1, 32'hFFFF_FFFF);
      send_event(3'd6, 1'b0, 32'd0);
      send_event(3'd7, 1'b1, 32'h5555_AAAA);
      // All channels at 1500 us: healthy goes high.
      for (int c = 0; c < DEF_CHANNELS; c++)
         send_pulse(CHANNEL_W'(c), 32'h8000_0000 + TS_W'(c), 32'd120000);
      // Channel 0 walked across both limits from the same start time.
      foreach (LIMIT_EDGE_TICKS[i])
         send_event(3'd0, 1'b0, 32'h8000_0000 + LIMIT_EDGE_TICKS[i]);

      // Random part across several limit settings, extremes included:
      // full window, min above max, zero-wide at zero and at the top.
      run_phase(16'd0,     16'd65535);
      run_phase(16'd65535, 16'd0);
      run_phase(16'd0,     16'd0);
      run_phase(16'd65535, 16'd65535);
      run_phase(16'd1200,  16'd1800);
      begin : rand_window
         logic [WIDTH_W-1:0] lo;
         lo = WIDTH_W'($urandom_range(0, 3000));
         run_phase(lo, lo + WIDTH_W'($urandom_range(0, 2000)));
      end
      run_phase(WIDTH_W'($urandom), WIDTH_W'($urandom));

      wait_until_drained();
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rcpw_pkg.sv
rtl/rcpw_tick_div.sv
rtl/rc_pulse_width_capture.sv
test/testbench.sv
